// File: rtl/twsm_pkg.sv
// Shared types, constants, day-word tables and number helpers for the time-window matcher.
`default_nettype none

package twsm_pkg;

    // Result codes.
    localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
    localparam logic [1:0] VERDICT_INSIDE  = 2'd1;
    localparam logic [1:0] VERDICT_SYNTAX  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_WEEKDAY = 1'b0;
    localparam logic CFG_MINUTE  = 1'b1;

    localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
    localparam logic [6:0]  HUNDREDS_MAX    = 7'd99;
    localparam int          WORD_COUNT      = 11;

    // Day words, lower case, padded with zero bytes.
    localparam logic [7:0] WORD_TEXT [WORD_COUNT][8] = '{
        '{"a", "n", "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "u", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "u", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "e", "v", "e", "r", 8'h00, 8'h00, 8'h00},
        '{"n", "o", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
        3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd4
    };
    localparam logic [6:0] WORD_DAYS [WORD_COUNT] = '{
        7'h7F, 7'h3E, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40, 7'h00, 7'h00
    };

    // A decimal field kept as hundreds and two low digits, saturating at 9999.
    typedef struct packed {
        logic [6:0] hi;
        logic [3:0] tens;
        logic [3:0] ones;
    } num_t;

    // One finished result.
    typedef struct packed {
        logic [1:0]  verdict;
        logic [18:0] seconds;
    } result_t;

    // Window test request from the parser to the evaluator.
    typedef struct packed {
        logic [6:0] day_mask;
        logic       whole_day;
        num_t       start_num;
        num_t       end_num;
    } eval_req_t;

    // Window test answer.
    typedef struct packed {
        logic        hit;
        logic [18:0] seconds;
    } eval_rsp_t;

    // Shift one decimal digit into a field, saturating at 9999.
    function automatic num_t num_append(input num_t n, input logic [3:0] d);
        logic [9:0] hi_new;
        num_t       r;
        hi_new = 10'(n.hi) * 10'd10 + 10'(n.tens);
        if (hi_new > 10'(HUNDREDS_MAX)) begin
            r.hi   = HUNDREDS_MAX;
            r.tens = 4'd9;
            r.ones = 4'd9;
        end else begin
            r.hi   = hi_new[6:0];
            r.tens = n.ones;
            r.ones = d;
        end
        return r;
    endfunction

    // hhmm read as hours times sixty plus minutes.
    function automatic logic [12:0] to_minutes(input num_t n);
        return 13'(n.hi) * 13'd60 + 13'(n.tens) * 13'd10 + 13'(n.ones);
    endfunction

endpackage

`default_nettype wire

// File: rtl/twsm_eval.sv
// Window test: day check, start/end compare and seconds to the end of the window.
`default_nettype none

module twsm_eval
    import twsm_pkg::*;
(
    input  wire eval_req_t   req,
    input  wire logic [2:0]  weekday,
    input  wire logic [10:0] minute,
    output eval_rsp_t        rsp
);

    logic [7:0]  mask_ext;
    logic        day_ok;
    logic [12:0] start_min;
    logic [12:0] end_min;
    logic [12:0] now_min;
    logic [12:0] diff;
    logic [18:0] open_secs;
    logic [18:0] wrap_secs;
    logic        open_hit;
    logic        wrap_hit;

    // The eighth mask bit is zero, so weekday seven never matches.
    assign mask_ext = {1'b0, req.day_mask};
    assign day_ok   = mask_ext[weekday];

    // A bare day word covers the whole day.
    assign start_min = req.whole_day ? 13'd0 : to_minutes(req.start_num);
    assign end_min   = req.whole_day ? 13'(MINUTES_PER_DAY) : to_minutes(req.end_num);
    assign now_min   = 13'(minute);

    // Ordinary window: strictly between start and end.
    assign open_hit  = (start_min < now_min) && (end_min > now_min);
    assign diff      = end_min - now_min;
    assign open_secs = 19'(diff) * 19'd60;

    // Wrapped window: after start or before end, counted to midnight.
    assign wrap_hit  = (now_min > start_min) || (now_min < end_min);
    assign wrap_secs = (minute < MINUTES_PER_DAY) ?
                       19'(MINUTES_PER_DAY - minute) * 19'd60 : 19'd0;

    always_comb begin
        if (start_min < end_min) begin
            rsp.hit     = day_ok && open_hit;
            rsp.seconds = open_secs;
        end else begin
            rsp.hit     = day_ok && wrap_hit;
            rsp.seconds = wrap_secs;
        end
    end

endmodule

`default_nettype wire

// File: rtl/twsm_core.sv
// Parser state and per-word next-state logic; one window test per word.
`default_nettype none

module twsm_core
    import twsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,
    input  wire logic [2:0]  weekday,
    input  wire logic [10:0] minute,
    output result_t          result
);

    // Parser modes.
    localparam logic [2:0] MODE_ENTRY     = 3'd0;
    localparam logic [2:0] MODE_AFTER_SEP = 3'd1;
    localparam logic [2:0] MODE_WORD      = 3'd2;
    localparam logic [2:0] MODE_DAYS      = 3'd3;
    localparam logic [2:0] MODE_START     = 3'd4;
    localparam logic [2:0] MODE_DASH      = 3'd5;
    localparam logic [2:0] MODE_END       = 3'd6;

    logic [2:0]            mode_reg, mode_next;
    logic [6:0]            mask_reg, mask_next;
    logic [WORD_COUNT-1:0] cand_reg, cand_next;
    logic [2:0]            pos_reg, pos_next;
    num_t                  start_reg, start_next;
    num_t                  end_reg, end_next;
    logic                  decided_reg, decided_next;
    logic [1:0]            verdict_reg, verdict_next;
    logic [18:0]           seconds_reg, seconds_next;

    logic                  is_digit;
    logic                  is_alpha;
    logic                  is_nul;
    logic                  is_sep;
    logic                  is_stop;
    logic [3:0]            digit;
    logic [7:0]            lower;
    logic [WORD_COUNT-1:0] cand_use;
    logic [2:0]            pos_use;
    logic [WORD_COUNT-1:0] keep;
    logic                  word_done;
    logic [6:0]            done_days;
    logic                  mask_clear;
    logic [6:0]            mask_word;
    logic                  num_mode;
    logic                  eval_now;
    num_t                  end_post;
    eval_req_t             ev_req;
    eval_rsp_t             ev_rsp;

    // Character classes.
    assign is_digit = (char_code >= "0") && (char_code <= "9");
    assign is_alpha = ((char_code >= "a") && (char_code <= "z")) ||
                      ((char_code >= "A") && (char_code <= "Z"));
    assign is_nul   = (char_code == 8'h00);
    assign is_sep   = (char_code == ",") || (char_code == "|");
    assign is_stop  = (char_code == ";");
    assign digit    = char_code[3:0];
    assign lower    = ((char_code >= "A") && (char_code <= "Z")) ?
                      (char_code | 8'h20) : char_code;

    // Day-word matcher: narrow the candidate set by one letter.
    assign cand_use   = (mode_reg == MODE_WORD) ? cand_reg : '1;
    assign pos_use    = (mode_reg == MODE_WORD) ? pos_reg : 3'd0;
    assign mask_clear = (mode_reg != MODE_WORD) && !((mode_reg == MODE_DAYS) && is_alpha);

    always_comb begin
        done_days = 7'd0;
        word_done = 1'b0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            keep[i] = cand_use[i] && (pos_use < WORD_LEN[i]) &&
                      (WORD_TEXT[i][pos_use] == lower);
            if (keep[i] && ({1'b0, WORD_LEN[i]} == ({1'b0, pos_use} + 4'd1))) begin
                word_done = 1'b1;
                done_days = done_days | WORD_DAYS[i];
            end
        end
    end

    assign mask_word = (mask_clear ? 7'd0 : mask_reg) | done_days;

    // The end field after this character, for a window closed by the final word.
    always_comb begin
        end_post = end_reg;
        if (is_digit && (mode_reg == MODE_DASH)) begin
            end_post = '{hi: 7'd0, tens: 4'd0, ones: digit};
        end else if (is_digit && (mode_reg == MODE_END)) begin
            end_post = num_append(end_reg, digit);
        end
    end

    // A window closes either on this character or at the end of the string.
    assign num_mode = (mode_reg == MODE_DASH) || (mode_reg == MODE_END);
    assign eval_now = ((mode_reg == MODE_DAYS) && !is_alpha && !is_digit) ||
                      ((mode_reg == MODE_END) && !is_digit);

    assign ev_req.day_mask  = (eval_now || num_mode) ? mask_reg : mask_word;
    assign ev_req.whole_day = !num_mode;
    assign ev_req.start_num = start_reg;
    assign ev_req.end_num   = end_post;

    twsm_eval u_eval (
        .req     (ev_req),
        .weekday (weekday),
        .minute  (minute),
        .rsp     (ev_rsp)
    );

    // Next parser state for an accepted word.
    always_comb begin
        logic do_entry;
        mode_next    = mode_reg;
        mask_next    = mask_reg;
        cand_next    = cand_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        decided_next = decided_reg;
        verdict_next = verdict_reg;
        seconds_next = seconds_reg;
        do_entry     = 1'b0;
        result       = '0;

        if (step_en) begin
            if (!decided_reg) begin
                if (is_nul) begin
                    // NUL ends the string here.
                    case (mode_reg)
                        MODE_DAYS, MODE_END: begin
                            if (ev_rsp.hit) begin
                                decided_next = 1'b1;
                                verdict_next = VERDICT_INSIDE;
                                seconds_next = ev_rsp.seconds;
                            end
                        end
                        MODE_WORD, MODE_START, MODE_DASH: begin
                            decided_next = 1'b1;
                            verdict_next = VERDICT_SYNTAX;
                            seconds_next = 19'd0;
                        end
                        default: begin
                        end
                    endcase
                    if (!decided_next) begin
                        decided_next = 1'b1;
                        verdict_next = VERDICT_OUTSIDE;
                        seconds_next = 19'd0;
                    end
                end else begin
                    case (mode_reg)
                        MODE_ENTRY, MODE_AFTER_SEP: begin
                            do_entry = 1'b1;
                        end
                        MODE_WORD: begin
                            do_entry = 1'b1;
                        end
                        MODE_DAYS: begin
                            if (is_alpha) begin
                                do_entry = 1'b1;
                            end else if (is_digit) begin
                                start_next = '{hi: 7'd0, tens: 4'd0, ones: digit};
                                mode_next  = MODE_START;
                            end else if (ev_rsp.hit) begin
                                decided_next = 1'b1;
                                verdict_next = VERDICT_INSIDE;
                                seconds_next = ev_rsp.seconds;
                            end else begin
                                do_entry = 1'b1;
                            end
                        end
                        MODE_START: begin
                            if (is_digit) begin
                                start_next = num_append(start_reg, digit);
                            end else if (char_code == "-") begin
                                mode_next = MODE_DASH;
                            end else begin
                                decided_next = 1'b1;
                                verdict_next = VERDICT_SYNTAX;
                                seconds_next = 19'd0;
                            end
                        end
                        MODE_DASH: begin
                            if (is_digit) begin
                                end_next  = end_post;
                                mode_next = MODE_END;
                            end else begin
                                decided_next = 1'b1;
                                verdict_next = VERDICT_SYNTAX;
                                seconds_next = 19'd0;
                            end
                        end
                        default: begin
                            if (is_digit) begin
                                end_next = end_post;
                            end else if (ev_rsp.hit) begin
                                decided_next = 1'b1;
                                verdict_next = VERDICT_INSIDE;
                                seconds_next = ev_rsp.seconds;
                            end else begin
                                do_entry = 1'b1;
                            end
                        end
                    endcase

                    // Separator, terminator or the first letter of a day word.
                    if (do_entry) begin
                        if (is_sep && (mode_reg != MODE_AFTER_SEP) &&
                            (mode_reg != MODE_WORD) && !((mode_reg == MODE_DAYS) && is_alpha)) begin
                            mode_next = MODE_AFTER_SEP;
                        end else if (is_stop && (mode_reg != MODE_WORD) &&
                                     !((mode_reg == MODE_DAYS) && is_alpha)) begin
                            decided_next = 1'b1;
                            verdict_next = VERDICT_OUTSIDE;
                            seconds_next = 19'd0;
                        end else if (keep == '0) begin
                            decided_next = 1'b1;
                            verdict_next = VERDICT_SYNTAX;
                            seconds_next = 19'd0;
                        end else if (word_done) begin
                            mask_next = mask_word;
                            cand_next = '0;
                            pos_next  = 3'd0;
                            mode_next = MODE_DAYS;
                        end else begin
                            mask_next = mask_clear ? 7'd0 : mask_reg;
                            cand_next = keep;
                            pos_next  = pos_use + 3'd1;
                            mode_next = MODE_WORD;
                        end
                    end
                end
            end

            // Final word: close an open entry, report, and start over.
            if (last_char) begin
                if (!decided_next) begin
                    case (mode_next)
                        MODE_DAYS, MODE_END: begin
                            if (ev_rsp.hit) begin
                                decided_next = 1'b1;
                                verdict_next = VERDICT_INSIDE;
                                seconds_next = ev_rsp.seconds;
                            end
                        end
                        MODE_WORD, MODE_START, MODE_DASH: begin
                            decided_next = 1'b1;
                            verdict_next = VERDICT_SYNTAX;
                            seconds_next = 19'd0;
                        end
                        default: begin
                        end
                    endcase
                    if (!decided_next) begin
                        verdict_next = VERDICT_OUTSIDE;
                        seconds_next = 19'd0;
                    end
                end
                result.verdict = verdict_next;
                result.seconds = seconds_next;
                mode_next    = MODE_ENTRY;
                mask_next    = 7'd0;
                cand_next    = '0;
                pos_next     = 3'd0;
                start_next   = '0;
                end_next     = '0;
                decided_next = 1'b0;
                verdict_next = VERDICT_OUTSIDE;
                seconds_next = 19'd0;
            end
        end
    end

    // Parser registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_ENTRY;
            mask_reg    <= 7'd0;
            cand_reg    <= '0;
            pos_reg     <= 3'd0;
            start_reg   <= '0;
            end_reg     <= '0;
            decided_reg <= 1'b0;
            verdict_reg <= VERDICT_OUTSIDE;
            seconds_reg <= 19'd0;
        end else begin
            mode_reg    <= mode_next;
            mask_reg    <= mask_next;
            cand_reg    <= cand_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            decided_reg <= decided_next;
            verdict_reg <= verdict_next;
            seconds_reg <= seconds_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/time_window_string_matcher.sv
// Top level: configuration registers, input word register, parser and result register.
//
// The block reads a time-window string one byte per word on the s_ channel
// (s_char_code, s_last_char marks the final byte) and gives one result word
// on the m_ channel for each string: m_verdict (outside, inside, syntax error)
// and m_seconds_left, the seconds to the end of the first matching window. The current
// weekday and minute are written via cfg_wr_en, cfg_addr and cfg_wdata by the user,
// only while no string is in progress (not enforced); a write takes effect at once.
//
// Throughput is one byte per cycle with no gaps between strings, while no final byte
// is held behind a waiting result. Each byte goes through the input register and the
// parser logic; the result word is registered on the m_ side as the final byte leaves
// the input register. Parser and window test are a single registered pass per byte.
//
// Reset clears the parser, the weekday and the minute, and empties both
// registers. While a result waits on m_ready low, bytes keep flowing; only a
// second final byte holds in the input register, and s_ready drops until the
// waiting result is taken.
`default_nettype none

module time_window_string_matcher
    import twsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_last_char,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_verdict,
    output logic [18:0]      m_seconds_left,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [10:0] cfg_wdata
);

    logic [2:0]  weekday_reg;
    logic [10:0] minute_reg;
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        m_valid_reg;
    logic [1:0]  m_verdict_reg;
    logic [18:0] m_seconds_reg;
    logic        advance;
    result_t     core_result;

    // A byte leaves the input register unless it is final and the result slot is busy.
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weekday_reg <= 3'd0;
            minute_reg  <= 11'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WEEKDAY: weekday_reg <= cfg_wdata[2:0];
                CFG_MINUTE:  minute_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
    end

    twsm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .weekday   (weekday_reg),
        .minute    (minute_reg),
        .result    (core_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_verdict_reg <= core_result.verdict;
            m_seconds_reg <= core_result.seconds;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict      = m_verdict_reg;
    assign m_seconds_left = m_seconds_reg;

    // Seconds are reported only for a match.
    a_seconds_only_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_verdict_reg == VERDICT_INSIDE) || (m_seconds_reg == 19'd0))
        else $error("seconds reported without a match");

    // No window can end more than 6039 minutes away, the saturated hhmm value 9999.
    a_seconds_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_seconds_reg <= 19'd362340))
        else $error("seconds beyond the largest window");

    // The input side stalls only behind a waiting result and a held final byte.
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_last_reg && m_valid_reg && !m_ready)
        else $error("input stalled without cause");

    // A final byte that leaves the input register always yields a result.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> m_valid_reg)
        else $error("final byte produced no result");

    // A result is lost only by being taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_seconds_reg))
        else $error("waiting result dropped");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the time-window string matcher, with its scoreboard and stimulus.
`timescale 1ns / 100ps

module testbench
    import twsm_pkg::*;
();

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 10;
    localparam int PHASE_BYTES  = 82;

    localparam int DAY_MINUTES = 1440;
    localparam int NUMBER_CAP  = 9999;
    localparam int DAY_WORDS   = 11;

    // Bytes with a meaning of their own in a window string.
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = "0";

    // Where the parser stands between two bytes.
    typedef enum logic [2:0] {
        P_ENTRY,
        P_AFTER_SEP,
        P_WORD,
        P_DAYS,
        P_START,
        P_DASH,
        P_END
    } parse_state_t;

    typedef struct {
        logic [1:0]  verdict;
        logic [18:0] seconds;
    } outcome_t;

    // Window scoreboard: tracks the parse of each string and queues the verdict it should give.
    class window_scoreboard;
        string        words [DAY_WORDS];
        logic [6:0]   masks [DAY_WORDS];
        logic [2:0]   weekday;
        logic [10:0]  minute;
        parse_state_t state;
        logic [6:0]   days;
        logic [10:0]  candidates;
        logic [2:0]   depth;
        int unsigned  first_num;
        int unsigned  second_num;
        bit           settled;
        logic [1:0]   held_verdict;
        logic [18:0]  held_secs;
        outcome_t     awaited [$];
        int unsigned  bytes_seen;
        int unsigned  strings_seen;
        int unsigned  n_inside;
        int unsigned  n_outside;
        int unsigned  n_syntax;
        int unsigned  errors;

        function new();
            words = '{"any", "wk", "su", "mo", "tu", "we", "th", "fr", "sa", "never", "none"};
            masks = '{7'h7F, 7'h3E, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40,
                      7'h00, 7'h00};
            weekday = '0;
            minute = '0;
            bytes_seen = 0;
            strings_seen = 0;
            n_inside = 0;
            n_outside = 0;
            n_syntax = 0;
            errors = 0;
            restart();
        endfunction

        function void set_reg(logic idx, logic [10:0] value);
            if (idx == CFG_WEEKDAY)
                weekday = value[2:0];
            else
                minute = value;
        endfunction

        function void restart();
            state = P_ENTRY;
            days = '0;
            candidates = '0;
            depth = '0;
            first_num = 0;
            second_num = 0;
            settled = 1'b0;
            held_verdict = VERDICT_OUTSIDE;
            held_secs = '0;
        endfunction

        function void settle(logic [1:0] v, logic [18:0] s);
            settled = 1'b1;
            held_verdict = v;
            held_secs = s;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function int unsigned grow(int unsigned n, logic [7:0] c);
            int unsigned v;
            v = n * 10 + int'(c - CH_ZERO);
            return v > NUMBER_CAP ? NUMBER_CAP : v;
        endfunction

        function int unsigned hhmm_minutes(int unsigned n);
            return (n / 100) * 60 + n % 100;
        endfunction

        // Test one window against the current day and minute; a wrapped window runs to midnight.
        function void try_window(int unsigned lo, int unsigned hi);
            int unsigned now_m;
            now_m = minute;
            if (weekday > 3'd6)
                return;
            if (!days[weekday])
                return;
            if (lo < hi) begin
                if (lo < now_m && hi > now_m)
                    settle(VERDICT_INSIDE, 19'((hi - now_m) * 60));
            end else if (now_m > lo || now_m < hi) begin
                settle(VERDICT_INSIDE,
                       now_m < DAY_MINUTES ? 19'((DAY_MINUTES - now_m) * 60) : 19'd0);
            end
        endfunction

        // Narrow the day-word candidates by one letter, without regard to case.
        function void letter(logic [7:0] c);
            logic [10:0] keep;
            logic [7:0]  lc;
            int          i;
            lc = c;
            if (c >= "A" && c <= "Z")
                lc = c + 8'd32;
            keep = '0;
            for (i = 0; i < DAY_WORDS; i++) begin
                if (candidates[i] && depth < words[i].len() && 8'(words[i][depth]) == lc)
                    keep[i] = 1'b1;
            end
            if (keep == '0) begin
                settle(VERDICT_SYNTAX, '0);
                return;
            end
            for (i = 0; i < DAY_WORDS; i++) begin
                if (keep[i] && words[i].len() == int'(depth) + 1) begin
                    days = days | masks[i];
                    candidates = '0;
                    depth = '0;
                    state = P_DAYS;
                    return;
                end
            end
            candidates = keep;
            depth = depth + 3'd1;
            state = P_WORD;
        endfunction

        function void open_word(logic [7:0] c);
            candidates = '1;
            depth = '0;
            letter(c);
        endfunction

        function void after_sep(logic [7:0] c);
            if (c == CH_SEMI) begin
                settle(VERDICT_OUTSIDE, '0);
                return;
            end
            days = '0;
            open_word(c);
        endfunction

        function void entry(logic [7:0] c);
            state = P_ENTRY;
            if (c == CH_COMMA || c == CH_BAR)
                state = P_AFTER_SEP;
            else
                after_sep(c);
        endfunction

        function void consume(logic [7:0] c);
            case (state)
                P_ENTRY: begin
                    entry(c);
                end
                P_AFTER_SEP: begin
                    after_sep(c);
                end
                P_WORD: begin
                    letter(c);
                end
                P_DAYS: begin
                    if (is_letter(c)) begin
                        open_word(c);
                    end else if (is_digit(c)) begin
                        first_num = int'(c - CH_ZERO);
                        state = P_START;
                    end else begin
                        try_window(0, DAY_MINUTES);
                        if (!settled)
                            entry(c);
                    end
                end
                P_START: begin
                    if (is_digit(c))
                        first_num = grow(first_num, c);
                    else if (c == CH_DASH)
                        state = P_DASH;
                    else
                        settle(VERDICT_SYNTAX, '0);
                end
                P_DASH: begin
                    if (is_digit(c)) begin
                        second_num = int'(c - CH_ZERO);
                        state = P_END;
                    end else begin
                        settle(VERDICT_SYNTAX, '0);
                    end
                end
                default: begin
                    if (is_digit(c)) begin
                        second_num = grow(second_num, c);
                    end else begin
                        try_window(hhmm_minutes(first_num), hhmm_minutes(second_num));
                        if (!settled)
                            entry(c);
                    end
                end
            endcase
        endfunction

        // End of string: finish a pending entry, or flag one that stopped halfway.
        function void close();
            case (state)
                P_DAYS: try_window(0, DAY_MINUTES);
                P_END: try_window(hhmm_minutes(first_num), hhmm_minutes(second_num));
                P_WORD, P_START, P_DASH: settle(VERDICT_SYNTAX, '0);
                default: ;
            endcase
            if (!settled)
                settle(VERDICT_OUTSIDE, '0);
        endfunction

        // Called for every accepted input word.
        function void note_word(logic [7:0] c, logic last);
            outcome_t o;
            bytes_seen++;
            if (!settled) begin
                if (c == CH_NUL)
                    close();
                else
                    consume(c);
            end
            if (!last)
                return;
            if (!settled)
                close();
            o.verdict = held_verdict;
            o.seconds = held_secs;
            awaited.push_back(o);
            strings_seen++;
            case (held_verdict)
                VERDICT_INSIDE: n_inside++;
                VERDICT_SYNTAX: n_syntax++;
                default: n_outside++;
            endcase
            restart();
        endfunction

        // Called for every accepted result word.
        function void check_result(logic [1:0] v, logic [18:0] s);
            outcome_t o;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: verdict %0d seconds %0d", $time, v, s);
                errors++;
                return;
            end
            o = awaited.pop_front();
            if (v !== o.verdict) begin
                $display("%0t: verdict mismatch: expected %0d, got %0d", $time, o.verdict, v);
                errors++;
            end
            if (s !== o.seconds) begin
                $display("%0t: seconds_left mismatch: expected %0d, got %0d",
                         $time, o.seconds, s);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = '0;
    logic        s_last_char = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_verdict;
    logic [18:0] m_seconds_left;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [10:0] cfg_wdata = '0;

    window_scoreboard sb = new();
    logic [7:0]       line [$];
    bit               calm = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      settings_used = 0;
    int unsigned      quiet = 0;

    time_window_string_matcher dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_last_char    (s_last_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_seconds_left (m_seconds_left),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: random stall before each word unless calm is set, plus one long hold when asked.
    initial begin : sink_proc
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
                @(posedge aclk);
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_verdict, m_seconds_left);
        end
    end

    task automatic write_reg(input logic idx, input logic [10:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Offer one byte after a random gap (none while calm is set) and wait until it is taken.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_char_code = c;
        s_last_char = last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(c, last);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line.size(); i++)
            send_byte(line[i], i == line.size() - 1);
    endtask

    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line.push_back(8'(s[i]));
    endfunction

    task automatic send_text(string s);
        line.delete();
        push_text(s);
        send_line();
    endtask

    // Wait for the block to drain so that the registers may be rewritten.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // A day word with each letter in random case.
    function automatic void push_word(int idx);
        int         i;
        logic [7:0] c;
        for (i = 0; i < sb.words[idx].len(); i++) begin
            c = 8'(sb.words[idx][i]);
            if ($urandom_range(0, 1))
                c = c - 8'd32;
            line.push_back(c);
        end
    endfunction

    function automatic void push_number(int unsigned n);
        if (n < 10000 && $urandom_range(0, 3) != 0)
            push_text($sformatf("%04d", n));
        else
            push_text($sformatf("%0d", n));
    endfunction

    // An hhmm value, mostly close to the current minute so that windows both hit and miss.
    function automatic int unsigned pick_hhmm();
        int m;
        case ($urandom_range(0, 9))
            6: return 0;
            7: return 2359;
            8: return $urandom_range(0, 9999);
            9: return $urandom_range(10000, 99999);
            default: begin
                if (sb.minute < DAY_MINUTES)
                    m = int'(sb.minute) + int'($urandom_range(0, 120)) - 60;
                else
                    m = int'($urandom_range(0, DAY_MINUTES - 1));
                if (m < 0)
                    m = 0;
                if (m > DAY_MINUTES - 1)
                    m = DAY_MINUTES - 1;
                return (m / 60) * 100 + m % 60;
            end
        endcase
    endfunction

    // Build one string: mostly well-formed entries, some noise and some damaged strings.
    function automatic void build_line();
        int unsigned kind;
        int unsigned entries;
        int unsigned n_words;
        int unsigned cut;
        int unsigned e;
        int unsigned w;
        line.delete();
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(0, 255)));
            return;
        end
        entries = $urandom_range(1, 3);
        for (e = 0; e < entries; e++) begin
            if (e != 0)
                line.push_back($urandom_range(0, 1) ? CH_COMMA : CH_BAR);
            n_words = $urandom_range(1, 2);
            for (w = 0; w < n_words; w++) begin
                if ($urandom_range(0, 1) && sb.weekday < 3'd7)
                    push_word(2 + int'(sb.weekday));
                else
                    push_word(int'($urandom_range(0, DAY_WORDS - 1)));
            end
            if ($urandom_range(0, 9) < 7) begin
                push_number(pick_hhmm());
                line.push_back(CH_DASH);
                push_number(pick_hhmm());
            end
        end
        case ($urandom_range(0, 9))
            6, 7: begin
                line.push_back(CH_SEMI);
                repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(1, 255)));
            end
            8, 9: begin
                line.push_back(CH_NUL);
                repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        if (kind < 5) begin
            if ($urandom_range(0, 1)) begin
                cut = $urandom_range(1, line.size());
                while (line.size() > cut)
                    void'(line.pop_back());
            end else begin
                line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
    endfunction

    // Main sequence: reset, directed strings, then random phases under several settings.
    initial begin : stim_proc
        int          phase;
        int unsigned sent;
        logic [2:0]  day;
        logic [10:0] mins;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wednesday, 10:00.
        write_reg(CFG_WEEKDAY, 11'd3);
        write_reg(CFG_MINUTE, 11'd600);
        settings_used++;
        line.delete();
        line.push_back(8'hFF);
        send_line();
        line.delete();
        line.push_back(CH_NUL);
        send_line();
        send_text("aNy");
        send_text("we2-1");
        send_text("we9-1001");
        send_text("sa1-");
        send_text("none;x");
        line.delete();
        push_text("we");
        line.push_back(CH_NUL);
        push_text("q");
        send_line();
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin day = 3'd0; mins = 11'd0; end
                1: begin day = 3'd6; mins = 11'd1439; end
                2: begin day = 3'd7; mins = 11'($urandom_range(0, DAY_MINUTES - 1)); end
                3: begin day = 3'($urandom_range(0, 6)); mins = 11'd2047; end
                4: begin day = 3'($urandom_range(0, 6)); mins = 11'd1440; end
                default: begin
                    day = 3'($urandom_range(0, 6));
                    mins = 11'($urandom_range(0, DAY_MINUTES - 1));
                end
            endcase
            // Upper bits of the weekday write are ignored by the block.
            write_reg(CFG_WEEKDAY, {8'($urandom_range(0, 255)), day});
            write_reg(CFG_MINUTE, mins);
            settings_used++;
            calm = (phase == 5);
            if (phase == 6)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_line();
                send_line();
                sent += line.size();
            end
            settle();
        end
        calm = 1'b0;

        $display("Sent %0d bytes in %0d strings under %0d register settings:",
                 sb.bytes_seen, sb.strings_seen, settings_used);
        $display("%0d inside, %0d outside, %0d syntax errors; random stalls and a %0d-cycle hold.",
                 sb.n_inside, sb.n_outside, sb.n_syntax, HOLD_CYCLES);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
